FILE: rtl/lhs_pkg.sv
// Shared types and constants for the link health supervisor.
`default_nettype none
package lhs_pkg;

    // Event codes carried in the input tuser field
    localparam logic [2:0] OP_SEND_SLOT   = 3'd0;
    localparam logic [2:0] OP_SEND_CHECK  = 3'd1;
    localparam logic [2:0] OP_CHECK_ANS   = 3'd2;
    localparam logic [2:0] OP_CHECK_TMO   = 3'd3;
    localparam logic [2:0] OP_DOWNLINK    = 3'd4;
    localparam logic [2:0] OP_JOIN_START  = 3'd5;
    localparam logic [2:0] OP_JOIN_POLL   = 3'd6;

    // Link states
    localparam logic [2:0] LS_IDLE      = 3'd0;
    localparam logic [2:0] LS_JOINING   = 3'd1;
    localparam logic [2:0] LS_HEALTHY   = 3'd2;
    localparam logic [2:0] LS_WARNING   = 3'd3;
    localparam logic [2:0] LS_RECONNECT = 3'd4;

    // Supervision timer commands
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_CHECK_INTERVAL = 3'd0;
    localparam logic [2:0] REG_WARN_FAIL      = 3'd1;
    localparam logic [2:0] REG_RECONN_FAIL    = 3'd2;
    localparam logic [2:0] REG_RECOVER_OK     = 3'd3;
    localparam logic [2:0] REG_REJOIN_CAP     = 3'd4;
    localparam logic [2:0] REG_BACKOFF_BASE   = 3'd5;
    localparam logic [2:0] REG_BACKOFF_CAP    = 3'd6;
    localparam logic [2:0] REG_CHECK_TMO      = 3'd7;

    // Register reset values
    localparam logic [7:0]  RST_CHECK_INTERVAL = 8'd5;
    localparam logic [7:0]  RST_WARN_FAIL      = 8'd3;
    localparam logic [7:0]  RST_RECONN_FAIL    = 8'd5;
    localparam logic [7:0]  RST_RECOVER_OK     = 8'd1;
    localparam logic        RST_REJOIN_CAP     = 1'b1;
    localparam logic [15:0] RST_BACKOFF_BASE   = 16'd60;
    localparam logic [15:0] RST_BACKOFF_CAP    = 16'd3600;
    localparam logic [7:0]  RST_CHECK_TMO      = 8'd10;

    localparam logic [15:0] FIRST_REJOIN_SEC = 16'd5;
    localparam logic [4:0]  MAX_BUSY_POLLS   = 5'd30;

    typedef struct packed {
        logic [7:0]  check_interval;
        logic [7:0]  warn_fail_limit;
        logic [7:0]  reconnect_fail_limit;
        logic [7:0]  recover_ok_limit;
        logic        rejoin_capable;
        logic [15:0] backoff_base_sec;
        logic [15:0] backoff_cap_sec;
        logic [7:0]  check_timeout_sec;
    } t_cfg;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] gateway_count;
        logic       request_failed;
        logic       send_failed;
        logic       tx_inhibit;
        logic       start_failed;
        logic       join_error;
        logic       mac_busy;
        logic       activated;
    } t_in;

    typedef struct packed {
        logic [2:0]  link_state;
        logic        tx_blocked;
        logic        with_check;
        logic [1:0]  timer_action;
        logic [15:0] timer_seconds;
        logic        join_request;
        logic        send_request;
        logic        check_pending;
    } t_out;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic bo_step;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bo_done;
    } t_sts;

endpackage
`default_nettype wire

FILE: rtl/link_health_supervisor.sv
// Top level: register port, stream packing and controller/datapath wiring.
`default_nettype none
// Link health supervisor. Takes one link event per input beat (opcode in
// tuser, event flags in tdata) and returns exactly one result beat with the
// new link state, the send/join requests and a supervision timer command.
// Each event is captured, runs through k backoff doublings and is then
// committed; k (0 to 15) is the number of doublings run by the iterative
// backoff unit: one doubling and cap compare per cycle, bounded by the
// current rejoin try count or by reaching the cap. One event is in work at a
// time; a finished result waits in the output register while the next beat
// is accepted. The user must write registers over the APB-style port only
// while no event is in work; the block does not enforce this. All eight sit
// at byte address 4*index, 32-bit data, unused high bits read as zero.
module link_health_supervisor #(
    parameter logic [4:0] MAX_BUSY_POLLS = lhs_pkg::MAX_BUSY_POLLS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // event input
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] gateway_count, [8] request_failed, [9] send_failed, [10] tx_inhibit,
    // [11] start_failed, [12] join_error, [13] mac_busy, [14] activated, [15] zero
    input  wire  [15:0] s_axis_tdata,
    // [2:0] operation
    input  wire  [2:0]  s_axis_tuser,
    // result output
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [2:0] link_state, [3] tx_blocked, [4] with_check, [6:5] timer_action,
    // [22:7] timer_seconds, [23] join_request, [24] send_request,
    // [25] check_pending, [31:26] zero
    output logic [31:0] m_axis_tdata,
    // register port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    lhs_pkg::t_cfg r_cfg;
    lhs_pkg::t_in  in_beat;
    lhs_pkg::t_out out_beat;
    lhs_pkg::t_cmd cmd;
    lhs_pkg::t_sts sts;
    logic [2:0]    reg_idx;
    logic          reg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign reg_wr  = psel && penable && pwrite && pready;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.check_interval       <= lhs_pkg::RST_CHECK_INTERVAL;
            r_cfg.warn_fail_limit      <= lhs_pkg::RST_WARN_FAIL;
            r_cfg.reconnect_fail_limit <= lhs_pkg::RST_RECONN_FAIL;
            r_cfg.recover_ok_limit     <= lhs_pkg::RST_RECOVER_OK;
            r_cfg.rejoin_capable       <= lhs_pkg::RST_REJOIN_CAP;
            r_cfg.backoff_base_sec     <= lhs_pkg::RST_BACKOFF_BASE;
            r_cfg.backoff_cap_sec      <= lhs_pkg::RST_BACKOFF_CAP;
            r_cfg.check_timeout_sec    <= lhs_pkg::RST_CHECK_TMO;
        end else if (reg_wr) begin
            case (reg_idx)
                lhs_pkg::REG_CHECK_INTERVAL: r_cfg.check_interval       <= pwdata[7:0];
                lhs_pkg::REG_WARN_FAIL:      r_cfg.warn_fail_limit      <= pwdata[7:0];
                lhs_pkg::REG_RECONN_FAIL:    r_cfg.reconnect_fail_limit <= pwdata[7:0];
                lhs_pkg::REG_RECOVER_OK:     r_cfg.recover_ok_limit     <= pwdata[7:0];
                lhs_pkg::REG_REJOIN_CAP:     r_cfg.rejoin_capable       <= pwdata[0];
                lhs_pkg::REG_BACKOFF_BASE:   r_cfg.backoff_base_sec     <= pwdata[15:0];
                lhs_pkg::REG_BACKOFF_CAP:    r_cfg.backoff_cap_sec      <= pwdata[15:0];
                lhs_pkg::REG_CHECK_TMO:      r_cfg.check_timeout_sec    <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // read back, zero-extended
    always_comb begin
        case (reg_idx)
            lhs_pkg::REG_CHECK_INTERVAL: prdata = {24'd0, r_cfg.check_interval};
            lhs_pkg::REG_WARN_FAIL:      prdata = {24'd0, r_cfg.warn_fail_limit};
            lhs_pkg::REG_RECONN_FAIL:    prdata = {24'd0, r_cfg.reconnect_fail_limit};
            lhs_pkg::REG_RECOVER_OK:     prdata = {24'd0, r_cfg.recover_ok_limit};
            lhs_pkg::REG_REJOIN_CAP:     prdata = {31'd0, r_cfg.rejoin_capable};
            lhs_pkg::REG_BACKOFF_BASE:   prdata = {16'd0, r_cfg.backoff_base_sec};
            lhs_pkg::REG_BACKOFF_CAP:    prdata = {16'd0, r_cfg.backoff_cap_sec};
            lhs_pkg::REG_CHECK_TMO:      prdata = {24'd0, r_cfg.check_timeout_sec};
            default:                     prdata = 32'd0;
        endcase
    end

    // unpack the input beat
    assign in_beat.operation      = s_axis_tuser;
    assign in_beat.gateway_count  = s_axis_tdata[7:0];
    assign in_beat.request_failed = s_axis_tdata[8];
    assign in_beat.send_failed    = s_axis_tdata[9];
    assign in_beat.tx_inhibit     = s_axis_tdata[10];
    assign in_beat.start_failed   = s_axis_tdata[11];
    assign in_beat.join_error     = s_axis_tdata[12];
    assign in_beat.mac_busy       = s_axis_tdata[13];
    assign in_beat.activated      = s_axis_tdata[14];

    // pack the result beat
    assign m_axis_tdata = {6'd0,
                           out_beat.check_pending,
                           out_beat.send_request,
                           out_beat.join_request,
                           out_beat.timer_seconds,
                           out_beat.timer_action,
                           out_beat.with_check,
                           out_beat.tx_blocked,
                           out_beat.link_state};

    lhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    lhs_dp #(
        .MAX_BUSY_POLLS (MAX_BUSY_POLLS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .i_in    (in_beat),
        .o_sts   (sts),
        .o_out   (out_beat)
    );

endmodule
`default_nettype wire

FILE: rtl/lhs_dp.sv
// Datapath: link state registers, backoff doubling unit and event update.
`default_nettype none
module lhs_dp #(
    parameter logic [4:0] MAX_BUSY_POLLS = lhs_pkg::MAX_BUSY_POLLS
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  lhs_pkg::t_cfg i_cfg,
    input  lhs_pkg::t_cmd i_cmd,
    input  lhs_pkg::t_in  i_in,
    output lhs_pkg::t_sts o_sts,
    output lhs_pkg::t_out o_out
);

    lhs_pkg::t_in  r_in;
    lhs_pkg::t_out r_out;

    // link state
    logic [2:0] r_mode, n_mode;
    logic [7:0] r_fail, n_fail;
    logic [7:0] r_ok, n_ok;
    logic [7:0] r_wfail, n_wfail;
    logic       r_force, n_force;
    logic       r_pend, n_pend;
    logic [7:0] r_phase, n_phase;
    logic       r_first, n_first;
    logic [3:0] r_tries, n_tries;
    logic [4:0] r_busy, n_busy;
    logic       r_init, n_init;

    // backoff unit
    logic [15:0] r_bo_val;
    logic [3:0]  r_bo_cnt;
    logic        r_bo_capped;
    logic [16:0] bo_dbl;
    logic [15:0] bo_secs;

    assign bo_dbl       = {r_bo_val, 1'b0};
    assign o_sts.bo_done = r_bo_capped || (r_bo_cnt == r_tries);
    assign bo_secs      = r_bo_capped ? i_cfg.backoff_cap_sec : r_bo_val;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in        <= i_in;
            r_bo_val    <= i_cfg.backoff_base_sec;
            r_bo_cnt    <= 4'd0;
            r_bo_capped <= 1'b0;
        end else if (i_cmd.bo_step) begin
            if (bo_dbl >= {1'b0, i_cfg.backoff_cap_sec}) begin
                r_bo_capped <= 1'b1;
            end else begin
                r_bo_val <= bo_dbl[15:0];
            end
            r_bo_cnt <= r_bo_cnt + 4'd1;
        end
    end

    // event update
    logic        res_blocked, res_with, res_join, res_send;
    logic [1:0]  res_tmr;
    logic [15:0] res_secs;
    logic        connected, want, dec, do_fail, do_ok, do_ftr;
    logic [8:0]  phase_inc;

    always_comb begin
        n_mode  = r_mode;
        n_fail  = r_fail;
        n_ok    = r_ok;
        n_wfail = r_wfail;
        n_force = r_force;
        n_pend  = r_pend;
        n_phase = r_phase;
        n_first = r_first;
        n_tries = r_tries;
        n_busy  = r_busy;
        n_init  = r_init;
        res_blocked = 1'b0;
        res_with    = 1'b0;
        res_join    = 1'b0;
        res_send    = 1'b0;
        res_tmr     = lhs_pkg::TMR_NONE;
        res_secs    = 16'd0;
        do_fail = 1'b0;
        do_ok   = 1'b0;
        do_ftr  = 1'b0;
        connected = (r_mode == lhs_pkg::LS_HEALTHY) || (r_mode == lhs_pkg::LS_WARNING);
        want = (i_cfg.check_interval != 8'd0) &&
               (r_force || !r_first || (r_phase == i_cfg.check_interval - 8'd1));
        dec  = !r_pend && want;
        phase_inc = {1'b0, r_phase} + 9'd1;

        case (r_in.operation)
            lhs_pkg::OP_SEND_SLOT: begin
                if (r_in.tx_inhibit) begin
                    // slot does nothing
                end else if (r_mode == lhs_pkg::LS_JOINING ||
                             r_mode == lhs_pkg::LS_RECONNECT) begin
                    res_blocked = 1'b1;
                end else begin
                    // a forced check is consumed only when no answer is awaited and checks are on
                    if (!r_pend && i_cfg.check_interval != 8'd0 && r_force) begin
                        n_force = 1'b0;
                    end
                    if (dec && !r_in.request_failed) begin
                        n_pend   = 1'b1;
                        res_tmr  = lhs_pkg::TMR_START;
                        res_secs = {8'd0, i_cfg.check_timeout_sec};
                    end
                    if (r_in.send_failed) begin
                        if (dec) begin
                            n_pend   = 1'b0;
                            res_tmr  = lhs_pkg::TMR_STOP;
                            res_secs = 16'd0;
                        end
                    end else begin
                        res_with = dec && !r_in.request_failed;
                        n_first  = 1'b1;
                        n_phase  = (phase_inc >= {1'b0, i_cfg.check_interval}) ?
                                   8'd0 : phase_inc[7:0];
                    end
                end
            end
            lhs_pkg::OP_SEND_CHECK: begin
                if (connected) begin
                    if (r_in.request_failed) begin
                        n_force = 1'b1;
                    end else begin
                        n_pend   = 1'b1;
                        res_with = 1'b1;
                        res_tmr  = lhs_pkg::TMR_START;
                        res_secs = {8'd0, i_cfg.check_timeout_sec};
                    end
                    res_send = 1'b1;
                end
            end
            lhs_pkg::OP_CHECK_ANS: begin
                res_tmr = lhs_pkg::TMR_STOP;
                if (r_in.gateway_count == 8'd0) begin
                    do_fail = 1'b1;
                end else begin
                    do_ok = 1'b1;
                end
            end
            lhs_pkg::OP_CHECK_TMO: begin
                if (r_mode == lhs_pkg::LS_RECONNECT) begin
                    res_join = 1'b1;
                end else if (r_mode != lhs_pkg::LS_JOINING && r_pend) begin
                    do_fail = 1'b1;
                end
            end
            lhs_pkg::OP_DOWNLINK: begin
                if (connected && r_pend) begin
                    res_tmr = lhs_pkg::TMR_STOP;
                    do_ok   = 1'b1;
                end
            end
            lhs_pkg::OP_JOIN_START: begin
                n_mode = lhs_pkg::LS_JOINING;
                if (!r_init && !i_cfg.rejoin_capable) begin
                    // fixed session: resume straight away
                    n_mode  = lhs_pkg::LS_HEALTHY;
                    n_fail  = 8'd0;
                    n_ok    = 8'd0;
                    n_wfail = 8'd0;
                    n_force = 1'b0;
                    n_phase = 8'd0;
                    n_first = 1'b0;
                    n_tries = 4'd0;
                    res_send = 1'b1;
                end else if (!r_init && r_in.start_failed) begin
                    do_ftr = 1'b1;
                end else begin
                    n_busy = 5'd0;
                    do_ftr = r_in.join_error;
                end
            end
            lhs_pkg::OP_JOIN_POLL: begin
                if (r_mode == lhs_pkg::LS_JOINING) begin
                    if (r_in.mac_busy) begin
                        n_busy = (r_busy == 5'd31) ? r_busy : r_busy + 5'd1;
                        if (n_busy >= MAX_BUSY_POLLS) begin
                            n_mode   = lhs_pkg::LS_RECONNECT;
                            n_tries  = 4'd0;
                            res_tmr  = lhs_pkg::TMR_START;
                            res_secs = i_cfg.backoff_base_sec;
                        end
                    end else if (!r_in.activated) begin
                        do_ftr = 1'b1;
                    end else begin
                        n_init  = 1'b0;
                        n_mode  = lhs_pkg::LS_HEALTHY;
                        n_fail  = 8'd0;
                        n_ok    = 8'd0;
                        n_wfail = 8'd0;
                        n_force = 1'b0;
                        n_phase = 8'd0;
                        n_first = 1'b0;
                        n_tries = 4'd0;
                        res_send = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (do_fail) begin
            n_pend = 1'b0;
            n_ok   = 8'd0;
            if (r_mode == lhs_pkg::LS_HEALTHY) begin
                n_fail = (r_fail == 8'hFF) ? r_fail : r_fail + 8'd1;
                if (n_fail >= i_cfg.warn_fail_limit) begin
                    n_mode  = lhs_pkg::LS_WARNING;
                    n_fail  = 8'd0;
                    n_wfail = 8'd0;
                    n_force = 1'b0;
                end
            end else if (r_mode == lhs_pkg::LS_WARNING) begin
                n_wfail = (r_wfail == 8'hFF) ? r_wfail : r_wfail + 8'd1;
                if (n_wfail >= i_cfg.reconnect_fail_limit) begin
                    n_wfail = 8'd0;
                    if (i_cfg.rejoin_capable) begin
                        n_mode   = lhs_pkg::LS_RECONNECT;
                        n_tries  = 4'd0;
                        res_tmr  = lhs_pkg::TMR_START;
                        res_secs = lhs_pkg::FIRST_REJOIN_SEC;
                    end
                end
            end
        end

        if (do_ok) begin
            n_pend = 1'b0;
            n_fail = 8'd0;
            if (r_mode == lhs_pkg::LS_HEALTHY) begin
                n_force = 1'b0;
            end else if (r_mode == lhs_pkg::LS_WARNING) begin
                n_ok = (r_ok == 8'hFF) ? r_ok : r_ok + 8'd1;
                if (n_ok >= i_cfg.recover_ok_limit) begin
                    n_mode  = lhs_pkg::LS_HEALTHY;
                    n_ok    = 8'd0;
                    n_wfail = 8'd0;
                    n_force = 1'b0;
                end else begin
                    n_force = 1'b1;
                end
            end
        end

        if (do_ftr) begin
            n_tries  = (r_tries == 4'hF) ? r_tries : r_tries + 4'd1;
            n_mode   = lhs_pkg::LS_RECONNECT;
            res_tmr  = lhs_pkg::TMR_START;
            res_secs = bo_secs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= lhs_pkg::LS_IDLE;
            r_fail  <= 8'd0;
            r_ok    <= 8'd0;
            r_wfail <= 8'd0;
            r_force <= 1'b0;
            r_pend  <= 1'b0;
            r_phase <= 8'd0;
            r_first <= 1'b0;
            r_tries <= 4'd0;
            r_busy  <= 5'd0;
            r_init  <= 1'b1;
        end else if (i_cmd.commit) begin
            r_mode  <= n_mode;
            r_fail  <= n_fail;
            r_ok    <= n_ok;
            r_wfail <= n_wfail;
            r_force <= n_force;
            r_pend  <= n_pend;
            r_phase <= n_phase;
            r_first <= n_first;
            r_tries <= n_tries;
            r_busy  <= n_busy;
            r_init  <= n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out.link_state    <= n_mode;
            r_out.tx_blocked    <= res_blocked;
            r_out.with_check    <= res_with;
            r_out.timer_action  <= res_tmr;
            r_out.timer_seconds <= res_secs;
            r_out.join_request  <= res_join;
            r_out.send_request  <= res_send;
            r_out.check_pending <= n_pend;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

FILE: rtl/lhs_ctrl.sv
// Controller: sequences capture, backoff doubling and commit of one beat.
`default_nettype none
module lhs_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    input  lhs_pkg::t_sts i_sts,
    output lhs_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_BACKOFF = 2'd1;
    localparam logic [1:0] S_COMMIT  = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free     = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = i_in_valid && o_in_ready;
    assign o_cmd.bo_step = (r_state == S_BACKOFF) && !i_sts.bo_done;
    assign o_cmd.commit  = (r_state == S_COMMIT) && slot_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) n_state = S_BACKOFF;
            end
            S_BACKOFF: begin
                if (i_sts.bo_done) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_cmd.commit ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_capture_to_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> (r_state == S_BACKOFF))
        else $error("capture did not start backoff");
    a_backoff_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BACKOFF) && i_sts.bo_done |=> (r_state == S_COMMIT))
        else $error("backoff done did not reach commit");
    a_commit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("commit did not present a result");
    a_no_step_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.bo_step |-> !o_cmd.capture && !o_cmd.commit)
        else $error("backoff step overlaps capture or commit");
`endif

endmodule
`default_nettype wire

FILE: test/link_health_supervisor_checker.sv
`timescale 1ns / 1ps
// Link health supervisor checker: follows both streams and the register port, predicts, compares.
module link_health_supervisor_checker
    import lhs_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    input  wire         s_axis_tready,
    input  wire  [15:0] s_axis_tdata,
    input  wire  [2:0]  s_axis_tuser,
    input  wire         m_axis_tvalid,
    input  wire         m_axis_tready,
    input  wire  [31:0] m_axis_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_outstanding
);

    t_cfg       cfg;

    // shadow of the supervisor state
    logic [2:0] mode;
    logic [7:0] fail_streak;
    logic [7:0] ok_streak;
    logic [7:0] warn_fails;
    logic       force_chk;
    logic       chk_pending;
    logic [7:0] msg_phase;
    logic       first_sent;
    logic [3:0] rejoin_tries;
    logic [4:0] busy_polls;
    logic       initial_join;

    // per-event scratch: timer command and send request
    logic [1:0]  tmr_cmd;
    logic [15:0] tmr_secs;
    logic        send_req;

    t_out link_results[$];
    t_in  seen_event;
    t_out predicted;
    t_out got;
    t_out want;
    int   mismatches;
    int   results_checked;

    assign o_fail_count = mismatches;

    initial begin
        mismatches      = 0;
        results_checked = 0;
    end

    task automatic report_mismatch(input string what);
        // keep the log readable when the design is badly off
        if (mismatches < 100)
            $display("%0t ns result %0d: %s", $time, results_checked, what);
        mismatches++;
    endtask

    function automatic logic [15:0] rejoin_backoff(input logic [3:0] tries);
        logic [31:0] secs;
        secs = {16'd0, cfg.backoff_base_sec};
        for (int i = 0; i < tries; i++) begin
            secs = secs << 1;
            if (secs >= cfg.backoff_cap_sec)
                return cfg.backoff_cap_sec;
        end
        return secs[15:0];
    endfunction

    task automatic start_timer(input logic [15:0] secs);
        tmr_cmd  = TMR_START;
        tmr_secs = secs;
    endtask

    task automatic stop_timer();
        tmr_cmd  = TMR_STOP;
        tmr_secs = '0;
    endtask

    task automatic go_reconnect();
        logic [15:0] secs;
        secs = rejoin_backoff(rejoin_tries);
        if (rejoin_tries != 4'hF)
            rejoin_tries++;
        mode = LS_RECONNECT;
        start_timer(secs);
    endtask

    task automatic restart_session();
        fail_streak  = '0;
        ok_streak    = '0;
        warn_fails   = '0;
        force_chk    = 1'b0;
        msg_phase    = '0;
        first_sent   = 1'b0;
        rejoin_tries = '0;
        send_req     = 1'b1;
    endtask

    task automatic note_failure();
        chk_pending = 1'b0;
        ok_streak   = '0;
        if (mode == LS_HEALTHY) begin
            if (fail_streak != 8'hFF)
                fail_streak++;
            if (fail_streak >= cfg.warn_fail_limit) begin
                mode        = LS_WARNING;
                fail_streak = '0;
                warn_fails  = '0;
                force_chk   = 1'b0;
            end
        end else if (mode == LS_WARNING) begin
            if (warn_fails != 8'hFF)
                warn_fails++;
            if (warn_fails >= cfg.reconnect_fail_limit) begin
                warn_fails = '0;
                if (cfg.rejoin_capable) begin
                    mode         = LS_RECONNECT;
                    rejoin_tries = '0;
                    start_timer(FIRST_REJOIN_SEC);
                end
            end
        end
    endtask

    task automatic note_success();
        chk_pending = 1'b0;
        fail_streak = '0;
        if (mode == LS_HEALTHY) begin
            force_chk = 1'b0;
        end else if (mode == LS_WARNING) begin
            if (ok_streak != 8'hFF)
                ok_streak++;
            if (ok_streak >= cfg.recover_ok_limit) begin
                mode       = LS_HEALTHY;
                ok_streak  = '0;
                warn_fails = '0;
                force_chk  = 1'b0;
            end else begin
                force_chk = 1'b1;
            end
        end
    endtask

    task automatic predict_event(input t_in ev, output t_out res);
        logic blocked;
        logic with_chk;
        logic join_req;
        logic dec;
        logic connected;
        blocked   = 1'b0;
        with_chk  = 1'b0;
        join_req  = 1'b0;
        dec       = 1'b0;
        connected = (mode == LS_HEALTHY) || (mode == LS_WARNING);
        tmr_cmd   = TMR_NONE;
        tmr_secs  = '0;
        send_req  = 1'b0;

        case (ev.operation)
            OP_SEND_SLOT: begin
                if (!ev.tx_inhibit) begin
                    if (mode == LS_JOINING || mode == LS_RECONNECT) begin
                        blocked = 1'b1;
                    end else begin
                        // a forced check is only consumed when no answer is awaited
                        if (!chk_pending && cfg.check_interval != 0) begin
                            if (force_chk) begin
                                force_chk = 1'b0;
                                dec       = 1'b1;
                            end else begin
                                dec = !first_sent || msg_phase == cfg.check_interval - 8'd1;
                            end
                        end
                        if (dec && !ev.request_failed) begin
                            chk_pending = 1'b1;
                            start_timer(16'(cfg.check_timeout_sec));
                        end
                        if (ev.send_failed) begin
                            if (dec) begin
                                chk_pending = 1'b0;
                                stop_timer();
                            end
                        end else begin
                            with_chk   = dec && !ev.request_failed;
                            first_sent = 1'b1;
                            msg_phase  = ({1'b0, msg_phase} + 9'd1 >= {1'b0, cfg.check_interval})
                                         ? 8'd0 : msg_phase + 8'd1;
                        end
                    end
                end
            end
            OP_SEND_CHECK: begin
                if (connected) begin
                    if (ev.request_failed) begin
                        force_chk = 1'b1;
                    end else begin
                        chk_pending = 1'b1;
                        with_chk    = 1'b1;
                        start_timer(16'(cfg.check_timeout_sec));
                    end
                    send_req = 1'b1;
                end
            end
            OP_CHECK_ANS: begin
                stop_timer();
                if (ev.gateway_count == 0)
                    note_failure();
                else
                    note_success();
            end
            OP_CHECK_TMO: begin
                if (mode == LS_RECONNECT)
                    join_req = 1'b1;
                else if (mode != LS_JOINING && chk_pending)
                    note_failure();
            end
            OP_DOWNLINK: begin
                if (connected && chk_pending) begin
                    stop_timer();
                    note_success();
                end
            end
            OP_JOIN_START: begin
                mode = LS_JOINING;
                if (!initial_join && !cfg.rejoin_capable) begin
                    mode = LS_HEALTHY;
                    restart_session();
                end else if (!initial_join && ev.start_failed) begin
                    go_reconnect();
                end else begin
                    busy_polls = '0;
                    if (ev.join_error)
                        go_reconnect();
                end
            end
            OP_JOIN_POLL: begin
                if (mode == LS_JOINING) begin
                    if (ev.mac_busy) begin
                        if (busy_polls != 5'h1F)
                            busy_polls++;
                        if (busy_polls >= MAX_BUSY_POLLS) begin
                            mode         = LS_RECONNECT;
                            rejoin_tries = '0;
                            start_timer(cfg.backoff_base_sec);
                        end
                    end else if (!ev.activated) begin
                        go_reconnect();
                    end else begin
                        initial_join = 1'b0;
                        mode         = LS_HEALTHY;
                        restart_session();
                    end
                end
            end
            default: begin
            end
        endcase

        res.link_state    = mode;
        res.tx_blocked    = blocked;
        res.with_check    = with_chk;
        res.timer_action  = tmr_cmd;
        res.timer_seconds = tmr_secs;
        res.join_request  = join_req;
        res.send_request  = send_req;
        res.check_pending = chk_pending;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.check_interval       = RST_CHECK_INTERVAL;
            cfg.warn_fail_limit      = RST_WARN_FAIL;
            cfg.reconnect_fail_limit = RST_RECONN_FAIL;
            cfg.recover_ok_limit     = RST_RECOVER_OK;
            cfg.rejoin_capable       = RST_REJOIN_CAP;
            cfg.backoff_base_sec     = RST_BACKOFF_BASE;
            cfg.backoff_cap_sec      = RST_BACKOFF_CAP;
            cfg.check_timeout_sec    = RST_CHECK_TMO;
            mode         = LS_IDLE;
            fail_streak  = '0;
            ok_streak    = '0;
            warn_fails   = '0;
            force_chk    = 1'b0;
            chk_pending  = 1'b0;
            msg_phase    = '0;
            first_sent   = 1'b0;
            rejoin_tries = '0;
            busy_polls   = '0;
            initial_join = 1'b1;
            link_results.delete();
            o_outstanding <= 0;
        end else begin
            // result side first: a beat leaving now belongs to an older event
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[2:0], m_axis_tdata[3], m_axis_tdata[4], m_axis_tdata[6:5],
                       m_axis_tdata[22:7], m_axis_tdata[23], m_axis_tdata[24],
                       m_axis_tdata[25]};
                if (link_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat %08h", m_axis_tdata));
                end else begin
                    want = link_results.pop_front();
                    if (got.link_state !== want.link_state)
                        report_mismatch($sformatf("link_state %0d, expected %0d",
                                                  got.link_state, want.link_state));
                    if (got.tx_blocked !== want.tx_blocked)
                        report_mismatch($sformatf("tx_blocked %0b, expected %0b",
                                                  got.tx_blocked, want.tx_blocked));
                    if (got.with_check !== want.with_check)
                        report_mismatch($sformatf("with_check %0b, expected %0b",
                                                  got.with_check, want.with_check));
                    if (got.timer_action !== want.timer_action)
                        report_mismatch($sformatf("timer_action %0d, expected %0d",
                                                  got.timer_action, want.timer_action));
                    if (got.timer_seconds !== want.timer_seconds)
                        report_mismatch($sformatf("timer_seconds %0d, expected %0d",
                                                  got.timer_seconds, want.timer_seconds));
                    if (got.join_request !== want.join_request)
                        report_mismatch($sformatf("join_request %0b, expected %0b",
                                                  got.join_request, want.join_request));
                    if (got.send_request !== want.send_request)
                        report_mismatch($sformatf("send_request %0b, expected %0b",
                                                  got.send_request, want.send_request));
                    if (got.check_pending !== want.check_pending)
                        report_mismatch($sformatf("check_pending %0b, expected %0b",
                                                  got.check_pending, want.check_pending));
                    if (m_axis_tdata[31:26] !== 6'd0)
                        report_mismatch($sformatf("pad bits %02h", m_axis_tdata[31:26]));
                end
                results_checked++;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                seen_event = {s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8], s_axis_tdata[9],
                              s_axis_tdata[10], s_axis_tdata[11], s_axis_tdata[12],
                              s_axis_tdata[13], s_axis_tdata[14]};
                predict_event(seen_event, predicted);
                link_results.push_back(predicted);
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_CHECK_INTERVAL: cfg.check_interval       = pwdata[7:0];
                    REG_WARN_FAIL:      cfg.warn_fail_limit      = pwdata[7:0];
                    REG_RECONN_FAIL:    cfg.reconnect_fail_limit = pwdata[7:0];
                    REG_RECOVER_OK:     cfg.recover_ok_limit     = pwdata[7:0];
                    REG_REJOIN_CAP:     cfg.rejoin_capable       = pwdata[0];
                    REG_BACKOFF_BASE:   cfg.backoff_base_sec     = pwdata[15:0];
                    REG_BACKOFF_CAP:    cfg.backoff_cap_sec      = pwdata[15:0];
                    REG_CHECK_TMO:      cfg.check_timeout_sec    = pwdata[7:0];
                    default: begin
                    end
                endcase
            end

            o_outstanding <= link_results.size();
        end
    end

endmodule

FILE: test/link_health_supervisor_tb.sv
`timescale 1ns / 1ps
// Link health supervisor testbench top: clock, reset, event and register stimulus, verdict.
module link_health_supervisor_tb;
    import lhs_pkg::*;

    // Opcode 3'd7 has no meaning; the block must pass state through untouched.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Event flag masks for directed beats, same order as tdata[14:8].
    localparam logic [6:0] F_NONE       = 7'b0000000;
    localparam logic [6:0] F_REQ_FAIL   = 7'b0000001;
    localparam logic [6:0] F_SEND_FAIL  = 7'b0000010;
    localparam logic [6:0] F_INHIBIT    = 7'b0000100;
    localparam logic [6:0] F_START_FAIL = 7'b0001000;
    localparam logic [6:0] F_JOIN_ERR   = 7'b0010000;
    localparam logic [6:0] F_BUSY       = 7'b0100000;
    localparam logic [6:0] F_ACTIVE     = 7'b1000000;

    // Drain time after the last result, covering an event with the longest backoff doubling run.
    localparam int DRAIN_CYCLES   = 24;
    // Long receiver hold-off: the result register and the event in work fill up,
    // so tready on the event side must drop.
    localparam int SQUEEZE_CYCLES = 200;
    // Nothing accepted for this long means the block is hung. Covers the squeeze,
    // the longest sender gap and the register phases with a wide margin.
    localparam int STALL_LIMIT    = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata;   // [7:0] gateway_count, [8] request_failed, [9] send_failed,
                                 // [10] tx_inhibit, [11] start_failed, [12] join_error,
                                 // [13] mac_busy, [14] activated, [15] zero
    logic [2:0]  s_axis_tuser;   // [2:0] operation
    wire         m_axis_tvalid;
    logic        m_axis_tready;
    wire  [31:0] m_axis_tdata;   // [2:0] link_state, [3] tx_blocked, [4] with_check,
                                 // [6:5] timer_action, [22:7] timer_seconds,
                                 // [23] join_request, [24] send_request,
                                 // [25] check_pending, [31:26] zero
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    wire  [31:0] prdata;
    wire         pready;

    int fail_count;
    int results_owed;
    int beats_sent;
    bit quiet;         // set for the closing phase: no idling on either side
    bit squeeze_req;   // asks the receiver process for one long hold-off

    link_health_supervisor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    link_health_supervisor_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (results_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hang detector: any beat on either stream resets the count.
    initial begin
        int idle_run;
        idle_run = 0;
        do begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_run = 0;
            else
                idle_run++;
        end while (idle_run < STALL_LIMIT);
        $display("link_health_supervisor_tb: FAIL");
        $finish;
    end

    // Result side backpressure: random stall bursts, one long squeeze on request,
    // always ready once the closing phase starts.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (squeeze_req) begin
                squeeze_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Directed beat: fixed gateway count and flag set.
    function automatic t_in evt(input logic [2:0] op, input logic [7:0] gw,
                                input logic [6:0] fl);
        t_in ev;
        ev.operation      = op;
        ev.gateway_count  = gw;
        ev.request_failed = fl[0];
        ev.send_failed    = fl[1];
        ev.tx_inhibit     = fl[2];
        ev.start_failed   = fl[3];
        ev.join_error     = fl[4];
        ev.mac_busy       = fl[5];
        ev.activated      = fl[6];
        return ev;
    endfunction

    // Random content for a given opcode. Failure flags are kept rare enough that
    // sessions actually come up; gateway count zero is common to drive failures.
    function automatic t_in rand_event(input logic [2:0] op);
        t_in ev;
        ev.operation      = op;
        ev.gateway_count  = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        ev.request_failed = ($urandom_range(0, 6) == 0);
        ev.send_failed    = ($urandom_range(0, 6) == 0);
        ev.tx_inhibit     = ($urandom_range(0, 9) == 0);
        ev.start_failed   = ($urandom_range(0, 5) == 0);
        ev.join_error     = ($urandom_range(0, 9) == 0);
        ev.mac_busy       = ($urandom_range(0, 3) == 0);
        ev.activated      = ($urandom_range(0, 4) != 0);
        return ev;
    endfunction

    // One event beat. tvalid stays high across back-to-back beats; a gap drops it
    // in the step right after the previous acceptance.
    task automatic push_event(input t_in ev);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= ev.operation;
        s_axis_tdata  <= {1'b0, ev.activated, ev.mac_busy, ev.join_error, ev.start_failed,
                          ev.tx_inhibit, ev.send_failed, ev.request_failed, ev.gateway_count};
        do @(posedge i_clk); while (!s_axis_tready);
        beats_sent++;
    endtask

    // Stop offering events, wait for every result, then let the block go quiet
    // before registers change.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle then access cycle; the register takes the value at the access edge.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input logic [7:0] interval, input logic [7:0] warn,
                               input logic [7:0] reconn, input logic [7:0] recover,
                               input logic rejoin, input logic [15:0] base,
                               input logic [15:0] cap, input logic [7:0] tmo);
        write_reg(REG_CHECK_INTERVAL, {24'd0, interval});
        write_reg(REG_WARN_FAIL,      {24'd0, warn});
        write_reg(REG_RECONN_FAIL,    {24'd0, reconn});
        write_reg(REG_RECOVER_OK,     {24'd0, recover});
        write_reg(REG_REJOIN_CAP,     {31'd0, rejoin});
        write_reg(REG_BACKOFF_BASE,   {16'd0, base});
        write_reg(REG_BACKOFF_CAP,    {16'd0, cap});
        write_reg(REG_CHECK_TMO,      {24'd0, tmo});
    endtask

    // Small limits so warning and reconnect are reached often; base and cap drawn
    // independently so base above cap shows up too.
    task automatic random_config();
        logic [15:0] base;
        logic [15:0] cap;
        base = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 400))
                                           : 16'($urandom_range(1, 65535));
        cap  = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 4000))
                                           : 16'($urandom_range(1, 65535));
        load_config(8'($urandom_range(0, 7)), 8'($urandom_range(1, 4)),
                    8'($urandom_range(1, 4)), 8'($urandom_range(1, 3)),
                    1'($urandom_range(0, 3) != 0), base, cap, 8'($urandom_range(1, 255)));
    endtask

    // Mostly well-formed link life cycles with random content, some noise.
    task automatic run_episode();
        int   kind;
        int   n;
        t_in  ev;
        kind = $urandom_range(0, 9);
        if (kind <= 5) begin
            // join, a few busy polls, then uplink traffic with answers, timeouts
            // and downlinks mixed in
            push_event(rand_event(OP_JOIN_START));
            n = $urandom_range(0, 3);
            repeat (n) begin
                ev = rand_event(OP_JOIN_POLL);
                ev.mac_busy = 1'b1;
                push_event(ev);
            end
            ev = rand_event(OP_JOIN_POLL);
            ev.mac_busy = 1'b0;
            push_event(ev);
            n = $urandom_range(4, 24);
            repeat (n) begin
                push_event(rand_event(($urandom_range(0, 4) == 0) ? OP_SEND_CHECK
                                                                   : OP_SEND_SLOT));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: push_event(rand_event(OP_CHECK_ANS));
                    4, 5:       push_event(rand_event(OP_CHECK_TMO));
                    6, 7:       push_event(rand_event(OP_DOWNLINK));
                    default: begin
                    end
                endcase
            end
        end else if (kind == 6) begin
            // failed rejoins in a row walk the backoff up toward the cap
            n = $urandom_range(2, 17);
            repeat (n) begin
                ev = rand_event(OP_JOIN_START);
                ev.start_failed = 1'b1;
                ev.join_error   = 1'($urandom_range(0, 1));
                push_event(ev);
            end
        end else if (kind == 7) begin
            // MAC stays busy for a run of polls around the poll limit
            ev = rand_event(OP_JOIN_START);
            ev.start_failed = 1'b0;
            ev.join_error   = 1'b0;
            push_event(ev);
            n = $urandom_range(28, 33);
            repeat (n) begin
                ev = rand_event(OP_JOIN_POLL);
                ev.mac_busy = 1'b1;
                push_event(ev);
            end
            push_event(rand_event(OP_CHECK_TMO));
        end else begin
            // noise, the unused opcode included
            n = $urandom_range(5, 15);
            repeat (n) push_event(rand_event(3'($urandom_range(0, 7))));
        end
    endtask

    task automatic run_phase(input int beat_target);
        while (beats_sent < beat_target)
            run_episode();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_SEND_SLOT;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        beats_sent    = 0;
        quiet         = 1'b0;
        squeeze_req   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk at reset register values.
        push_event(evt(OP_UNUSED,     8'd0,   F_NONE));                    // no effect
        push_event(evt(OP_SEND_SLOT,  8'd0,   F_INHIBIT));                 // slot ignored
        push_event(evt(OP_SEND_SLOT,  8'd0,   F_REQ_FAIL | F_SEND_FAIL));  // refused both: stop
        push_event(evt(OP_SEND_SLOT,  8'd0,   F_NONE));                    // first send in idle
        push_event(evt(OP_CHECK_TMO,  8'd0,   F_NONE));                    // clears pending
        push_event(evt(OP_JOIN_START, 8'd0,   F_JOIN_ERR));                // to reconnect
        push_event(evt(OP_SEND_SLOT,  8'd0,   F_NONE));                    // blocked
        push_event(evt(OP_CHECK_TMO,  8'd0,   F_NONE));                    // join request
        push_event(evt(OP_JOIN_START, 8'd0,   F_NONE));
        push_event(evt(OP_JOIN_POLL,  8'd0,   F_NONE));                    // not activated
        push_event(evt(OP_JOIN_START, 8'd0,   F_START_FAIL));              // ignored on first join
        push_event(evt(OP_JOIN_POLL,  8'd0,   F_BUSY | F_ACTIVE));
        push_event(evt(OP_JOIN_POLL,  8'd0,   F_ACTIVE));                  // healthy
        push_event(evt(OP_SEND_SLOT,  8'd0,   F_NONE));                    // check on first send
        push_event(evt(OP_DOWNLINK,   8'd0,   F_NONE));                    // counts as answer
        push_event(evt(OP_SEND_CHECK, 8'd0,   F_REQ_FAIL));                // forces a retry
        push_event(evt(OP_SEND_SLOT,  8'd0,   F_REQ_FAIL));                // retry refused too
        push_event(evt(OP_SEND_CHECK, 8'd0,   F_NONE));
        push_event(evt(OP_CHECK_TMO,  8'd0,   F_NONE));                    // failure 1
        push_event(evt(OP_CHECK_ANS,  8'd0,   F_NONE));                    // failure 2
        push_event(evt(OP_CHECK_ANS,  8'd0,   F_NONE));                    // warning
        push_event(evt(OP_CHECK_ANS,  8'd255, F_NONE));                    // back to healthy
        push_event(evt(OP_JOIN_START, 8'd0,   F_START_FAIL));              // rejoin fails

        // Low extremes: every threshold trips on the first event.
        settle();
        load_config(8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 16'd1, 16'd1, 8'd1);
        run_phase(160);

        // High extremes, fixed session.
        settle();
        load_config(8'd255, 8'd255, 8'd255, 8'd255, 1'b0, 16'hFFFF, 16'hFFFF, 8'd255);
        run_phase(260);

        // Checks off, base above cap, with the long result-side hold-off.
        settle();
        load_config(8'd0, 8'd2, 8'd2, 8'd2, 1'b1, 16'd5000, 16'd700, 8'd30);
        squeeze_req = 1'b1;
        run_phase(360);

        repeat (5) begin
            settle();
            random_config();
            run_phase(beats_sent + 80);
        end

        // Closing phase at full rate.
        settle();
        quiet = 1'b1;
        random_config();
        run_phase(850);
        settle();

        if (fail_count == 0)
            $display("link_health_supervisor_tb: PASS");
        else
            $display("link_health_supervisor_tb: FAIL");
        $finish;
    end

endmodule
